[sv/nfd_pkg.sv]
package nfd_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int EXT_LEN_BITS = 16;

  typedef logic [LENGTH_BITS-1:0]  len_t;
  typedef logic [EXT_LEN_BITS-1:0] ext_len_t;

  // phase codes
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_EXT    = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_DCS    = 3'd3;
  localparam logic [2:0] PH_POST   = 3'd4;

  // result kinds
  localparam logic [2:0] K_PAYLOAD    = 3'd0;
  localparam logic [2:0] K_OK         = 3'd1;
  localparam logic [2:0] K_BAD_START  = 3'd2;
  localparam logic [2:0] K_LEN_CKSUM  = 3'd3;
  localparam logic [2:0] K_DATA_CKSUM = 3'd4;
  localparam logic [2:0] K_BAD_POST   = 3'd5;
  localparam logic [2:0] K_TIMEOUT    = 3'd6;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [7:0] START_0 = 8'h00;
  localparam logic [7:0] START_1 = 8'h00;
  localparam logic [7:0] START_2 = 8'hff;
  localparam logic [7:0] EXT_MARK = 8'hff;
  localparam logic [7:0] POSTAMBLE = 8'h00;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_data;
    logic       last;
  } out_t;

  // result of processing one word in the core
  typedef struct packed {
    logic vld;
    out_t word;
  } res_t;

endpackage

[sv/nfd_in_reg.sv]
module nfd_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nfd_pkg::in_t  in_word,
  input  logic          take,
  output logic          valid_r,
  output nfd_pkg::in_t  word_r
);

  logic load;

  assign load     = take || !valid_r;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      word_r <= in_word;
    end
  end

endmodule

[sv/nfd_core.sv]
module nfd_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  nfd_pkg::in_t  word,
  output nfd_pkg::res_t res
);

  logic [2:0]     phase_r, phase_nxt;
  logic [2:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]     hdr_r [0:2];
  logic [7:0]     hdr_nxt [0:2];
  nfd_pkg::len_t  frame_len_r, frame_len_nxt;
  nfd_pkg::len_t  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]     data_sum_r, data_sum_nxt;
  logic           start_bad_r, start_bad_nxt;

  logic [2:0]        ph;
  logic [2:0]        hc;
  logic              sb;
  logic [7:0]        b;
  logic              fin;
  logic [2:0]        fin_kind;
  logic              go_body;
  nfd_pkg::ext_len_t body_len;
  nfd_pkg::len_t     cnt_inc;
  logic [7:0]        sum_inc;

  always_comb begin
    // unused phase codes behave as header collection
    ph = (phase_r > nfd_pkg::PH_POST) ? nfd_pkg::PH_HEADER : phase_r;
    hc = (phase_r > nfd_pkg::PH_POST) ? 3'd0 : hdr_cnt_r;
    sb = (phase_r > nfd_pkg::PH_POST) ? 1'b0 : start_bad_r;
    b  = word.rx_byte;

    phase_nxt     = ph;
    hdr_cnt_nxt   = hc;
    start_bad_nxt = sb;
    hdr_nxt       = hdr_r;
    frame_len_nxt = frame_len_r;
    byte_cnt_nxt  = byte_cnt_r;
    data_sum_nxt  = data_sum_r;

    fin      = 1'b0;
    fin_kind = nfd_pkg::K_OK;
    go_body  = 1'b0;
    body_len = '0;
    cnt_inc  = nfd_pkg::len_t'(byte_cnt_r + 1'b1);
    sum_inc  = 8'(data_sum_r + b);
    res      = '0;

    if (word.cmd == nfd_pkg::CMD_TIMEOUT) begin
      if (!(ph == nfd_pkg::PH_HEADER && hc == 3'd0)) begin
        fin      = 1'b1;
        fin_kind = nfd_pkg::K_TIMEOUT;
      end
    end else begin
      unique case (ph)
        nfd_pkg::PH_HEADER: begin
          if (hc < 3'd3) begin
            hdr_nxt[hc[1:0]] = b;
            hdr_cnt_nxt      = 3'(hc + 1'b1);
          end else if (hc == 3'd3) begin
            start_bad_nxt = (hdr_r[0] != nfd_pkg::START_0) ||
                            (hdr_r[1] != nfd_pkg::START_1) ||
                            (hdr_r[2] != nfd_pkg::START_2);
            hdr_nxt[0]  = b;
            hdr_cnt_nxt = 3'd4;
          end else if (sb) begin
            fin      = 1'b1;
            fin_kind = nfd_pkg::K_BAD_START;
          end else if (hdr_r[0] == nfd_pkg::EXT_MARK && b == nfd_pkg::EXT_MARK) begin
            phase_nxt   = nfd_pkg::PH_EXT;
            hdr_cnt_nxt = 3'd0;
          end else if (8'(hdr_r[0] + b) != 8'h00) begin
            fin      = 1'b1;
            fin_kind = nfd_pkg::K_LEN_CKSUM;
          end else begin
            go_body  = 1'b1;
            body_len = nfd_pkg::ext_len_t'(hdr_r[0]);
          end
        end
        nfd_pkg::PH_EXT: begin
          if (hc < 3'd2) begin
            hdr_nxt[hc[1:0]] = b;
            hdr_cnt_nxt      = 3'(hc + 1'b1);
          end else if (8'(hdr_r[0] + hdr_r[1] + b) != 8'h00) begin
            fin      = 1'b1;
            fin_kind = nfd_pkg::K_LEN_CKSUM;
          end else begin
            go_body  = 1'b1;
            body_len = {hdr_r[0], hdr_r[1]};
          end
        end
        nfd_pkg::PH_BODY: begin
          data_sum_nxt = sum_inc;
          byte_cnt_nxt = cnt_inc;
          if (cnt_inc >= frame_len_r) begin
            phase_nxt = nfd_pkg::PH_DCS;
          end
          res.vld           = 1'b1;
          res.word.kind     = nfd_pkg::K_PAYLOAD;
          res.word.out_data = b;
          res.word.last     = 1'b0;
        end
        nfd_pkg::PH_DCS: begin
          if (sum_inc != 8'h00) begin
            fin      = 1'b1;
            fin_kind = nfd_pkg::K_DATA_CKSUM;
          end else begin
            phase_nxt = nfd_pkg::PH_POST;
          end
        end
        default: begin
          fin      = 1'b1;
          fin_kind = (b == nfd_pkg::POSTAMBLE) ? nfd_pkg::K_OK : nfd_pkg::K_BAD_POST;
        end
      endcase
    end

    if (go_body) begin
      // zero length or one that does not fit the counter is a length error
      if (body_len == '0 || (body_len >> nfd_pkg::LENGTH_BITS) != '0) begin
        fin      = 1'b1;
        fin_kind = nfd_pkg::K_LEN_CKSUM;
      end else begin
        frame_len_nxt = body_len[nfd_pkg::LENGTH_BITS-1:0];
        byte_cnt_nxt  = '0;
        data_sum_nxt  = '0;
        phase_nxt     = nfd_pkg::PH_BODY;
      end
    end

    if (fin) begin
      phase_nxt         = nfd_pkg::PH_HEADER;
      hdr_cnt_nxt       = 3'd0;
      start_bad_nxt     = 1'b0;
      res.vld           = 1'b1;
      res.word.kind     = fin_kind;
      res.word.out_data = 8'h00;
      res.word.last     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= nfd_pkg::PH_HEADER;
      hdr_cnt_r   <= 3'd0;
      start_bad_r <= 1'b0;
      hdr_r[0]    <= 8'h00;
      hdr_r[1]    <= 8'h00;
      hdr_r[2]    <= 8'h00;
      frame_len_r <= '0;
      byte_cnt_r  <= '0;
      data_sum_r  <= 8'h00;
    end else if (go) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      start_bad_r <= start_bad_nxt;
      hdr_r       <= hdr_nxt;
      frame_len_r <= frame_len_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      data_sum_r  <= data_sum_nxt;
    end
  end

endmodule

[sv/nfd_out_reg.sv]
module nfd_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  nfd_pkg::out_t res_word,
  output logic          out_valid,
  input  logic          out_stall,
  output nfd_pkg::out_t out_word
);

  logic          valid_r;
  nfd_pkg::out_t word_r;

  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= res_word;
    end
  end

endmodule

[sv/nfd_information_frame_deframer_placeholder_unused.sv]
module nfd_word_gate (
  input  logic          in_vld,
  input  nfd_pkg::res_t res,
  input  logic          out_valid,
  input  logic          out_stall,
  output logic          go,
  output logic          load
);

  // a word is processed when its result, if any, has a free output slot
  assign go   = in_vld && (!res.vld || !out_valid || !out_stall);
  assign load = go && res.vld;

endmodule

[sv/nfc_information_frame_deframer.sv]
// Order: an accepted word waits in the input register; when it is processed,
//   its result is loaded into the output register and offered on out_valid.
// Throughput: one word per cycle, set by the single-pass deframer between
//   the input register and the output register; a result held by out_stall
//   stalls the input only while the next word also yields a result.
// Reset: synchronous, active low; clears both valid flags and returns the
//   deframer to header collection with all counters and sums at zero.
module nfc_information_frame_deframer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nfd_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output nfd_pkg::out_t out_word
);

  logic          in_vld_r;
  nfd_pkg::in_t  in_word_r;
  nfd_pkg::res_t res;
  logic          go;
  logic          load;

  nfd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .take     (go),
    .valid_r  (in_vld_r),
    .word_r   (in_word_r)
  );

  nfd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .word  (in_word_r),
    .res   (res)
  );

  nfd_word_gate u_gate (
    .in_vld    (in_vld_r),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .go        (go),
    .load      (load)
  );

  nfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_word  (res.word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !load)
    else $error("result overwritten while stalled");

  // payload words and status words are told apart by last alone
  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.kind == nfd_pkg::K_PAYLOAD) != out_word.last))
    else $error("kind and last disagree");

  a_status_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last) |-> (out_word.out_data == 8'h00))
    else $error("status word carries data");

  // a processed word with a result always shows up on the output
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("result lost");

endmodule

[tb/nfc_information_frame_deframer_tb.sv]
module nfc_information_frame_deframer_tb;

  typedef enum int {
    F_NONE, F_START, F_LCS, F_ZERO_LEN, F_DCS, F_POST, F_TIMEOUT, F_NOISE
  } fault_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  nfd_pkg::in_t  in_word = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  nfd_pkg::out_t out_word;

  nfc_information_frame_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // deframer state as tracked by the testbench
  logic [2:0]  ph;
  logic [2:0]  hdr_cnt;
  logic [7:0]  hdr [3];
  logic [15:0] frame_len;
  logic [15:0] byte_cnt;
  logic [7:0]  dsum;
  logic        start_bad;

  nfd_pkg::out_t expected_words [$];
  nfd_pkg::out_t want;
  int   errors = 0;
  int   words_sent = 0;
  bit   no_gaps = 1'b0;
  int   long_hold = 0;
  int   stall_left = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void close_frame(input logic [2:0] kind, output nfd_pkg::out_t r);
    ph = nfd_pkg::PH_HEADER;
    hdr_cnt = 3'd0;
    start_bad = 1'b0;
    r = '{kind: kind, out_data: 8'h00, last: 1'b1};
  endfunction

  function automatic bit open_body(input logic [15:0] len, output nfd_pkg::out_t r);
    r = '0;
    if (len == 16'd0) begin
      close_frame(nfd_pkg::K_LEN_CKSUM, r);
      return 1'b1;
    end
    frame_len = len;
    byte_cnt = 16'd0;
    dsum = 8'h00;
    ph = nfd_pkg::PH_BODY;
    return 1'b0;
  endfunction

  // one received word -> at most one expected result word
  function automatic bit deframe(input nfd_pkg::in_t w, output nfd_pkg::out_t r);
    logic [7:0] b;
    logic [7:0] s;
    b = w.rx_byte;
    r = '0;
    if (ph > nfd_pkg::PH_POST) begin
      ph = nfd_pkg::PH_HEADER;
      hdr_cnt = 3'd0;
      start_bad = 1'b0;
    end
    if (w.cmd == nfd_pkg::CMD_TIMEOUT) begin
      // idle timeout is ignored
      if (ph == nfd_pkg::PH_HEADER && hdr_cnt == 3'd0) return 1'b0;
      close_frame(nfd_pkg::K_TIMEOUT, r);
      return 1'b1;
    end
    unique case (ph)
      nfd_pkg::PH_HEADER: begin
        if (hdr_cnt < 3'd3) begin
          hdr[hdr_cnt] = b;
          hdr_cnt++;
          return 1'b0;
        end
        if (hdr_cnt == 3'd3) begin
          start_bad = hdr[0] != nfd_pkg::START_0 || hdr[1] != nfd_pkg::START_1 ||
                      hdr[2] != nfd_pkg::START_2;
          hdr[0] = b;
          hdr_cnt = 3'd4;
          return 1'b0;
        end
        // start code verdict waits for the fifth byte
        if (start_bad) begin
          close_frame(nfd_pkg::K_BAD_START, r);
          return 1'b1;
        end
        if (hdr[0] == nfd_pkg::EXT_MARK && b == nfd_pkg::EXT_MARK) begin
          ph = nfd_pkg::PH_EXT;
          hdr_cnt = 3'd0;
          return 1'b0;
        end
        s = hdr[0] + b;
        if (s != 8'h00) begin
          close_frame(nfd_pkg::K_LEN_CKSUM, r);
          return 1'b1;
        end
        return open_body({8'h00, hdr[0]}, r);
      end
      nfd_pkg::PH_EXT: begin
        if (hdr_cnt < 3'd2) begin
          hdr[hdr_cnt] = b;
          hdr_cnt++;
          return 1'b0;
        end
        s = hdr[0] + hdr[1] + b;
        if (s != 8'h00) begin
          close_frame(nfd_pkg::K_LEN_CKSUM, r);
          return 1'b1;
        end
        return open_body({hdr[0], hdr[1]}, r);
      end
      nfd_pkg::PH_BODY: begin
        dsum = dsum + b;
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= frame_len) ph = nfd_pkg::PH_DCS;
        r = '{kind: nfd_pkg::K_PAYLOAD, out_data: b, last: 1'b0};
        return 1'b1;
      end
      nfd_pkg::PH_DCS: begin
        s = dsum + b;
        if (s != 8'h00) begin
          close_frame(nfd_pkg::K_DATA_CKSUM, r);
          return 1'b1;
        end
        ph = nfd_pkg::PH_POST;
        return 1'b0;
      end
      default: begin
        close_frame(b == nfd_pkg::POSTAMBLE ? nfd_pkg::K_OK : nfd_pkg::K_BAD_POST, r);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_word(input nfd_pkg::in_t w);
    nfd_pkg::out_t r;
    int   gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (deframe(w, r)) expected_words.push_back(r);
  endtask

  function automatic nfd_pkg::in_t byte_word(input logic [7:0] b);
    return '{cmd: nfd_pkg::CMD_BYTE, rx_byte: b};
  endfunction

  function automatic nfd_pkg::in_t timeout_word();
    return '{cmd: nfd_pkg::CMD_TIMEOUT, rx_byte: 8'($urandom)};
  endfunction

  function automatic logic [7:0] flip_mask();
    return 8'($urandom_range(1, 255));
  endfunction

  // builds a frame of len payload bytes with at most one fault and sends it
  task automatic send_frame(input fault_t fault, input bit ext, input int len);
    nfd_pkg::in_t words [$];
    logic [15:0] n;
    logic [7:0] sum;
    logic [7:0] b;
    int         pos;
    n = (fault == F_ZERO_LEN) ? 16'd0 : 16'(len);
    words.push_back(byte_word(nfd_pkg::START_0));
    words.push_back(byte_word(nfd_pkg::START_1));
    words.push_back(byte_word(nfd_pkg::START_2));
    if (fault == F_START) begin
      pos = $urandom_range(2);
      words[pos].rx_byte = words[pos].rx_byte ^ flip_mask();
    end
    if (ext) begin
      sum = 8'h00 - n[15:8] - n[7:0];
      words.push_back(byte_word(nfd_pkg::EXT_MARK));
      words.push_back(byte_word(nfd_pkg::EXT_MARK));
      words.push_back(byte_word(n[15:8]));
      words.push_back(byte_word(n[7:0]));
      words.push_back(byte_word(sum));
    end else begin
      sum = 8'h00 - n[7:0];
      words.push_back(byte_word(n[7:0]));
      words.push_back(byte_word(sum));
    end
    if (fault == F_START) begin
      while (words.size() > 5) void'(words.pop_back());
    end else if (fault == F_LCS) begin
      words[words.size()-1].rx_byte = words[words.size()-1].rx_byte ^ flip_mask();
    end else if (fault != F_ZERO_LEN) begin
      sum = 8'h00;
      for (int i = 0; i < int'(n); i++) begin
        b = 8'($urandom);
        sum = sum + b;
        words.push_back(byte_word(b));
      end
      sum = 8'h00 - sum;
      if (fault == F_DCS) sum = sum ^ flip_mask();
      words.push_back(byte_word(sum));
      words.push_back(byte_word(fault == F_POST ? flip_mask() : nfd_pkg::POSTAMBLE));
    end
    if (fault == F_TIMEOUT) begin
      pos = $urandom_range(1, words.size());
      words.insert(pos, timeout_word());
    end
    foreach (words[k]) send_word(words[k]);
  endtask

  // a timeout brings the deframer back to header collection
  task automatic resync_header();
    if (ph != nfd_pkg::PH_HEADER || hdr_cnt != 3'd0) send_word(timeout_word());
  endtask

  task automatic test_directed();
    send_word('{cmd: nfd_pkg::CMD_TIMEOUT, rx_byte: 8'hff});
    send_frame(F_NONE, 1'b0, 1);
    send_frame(F_START, 1'b0, 1);
    send_frame(F_ZERO_LEN, 1'b1, 0);
    send_word(byte_word(8'h00));
    send_word(byte_word(8'hff));
    send_word('{cmd: nfd_pkg::CMD_TIMEOUT, rx_byte: 8'h00});
    resync_header();
  endtask

  task automatic test_backpressure();
    long_hold <= 300;
    no_gaps = 1'b1;
    repeat (3) send_frame(F_NONE, 1'b0, 40);
    no_gaps = 1'b0;
    resync_header();
  endtask

  task automatic test_random_frames();
    int     first;
    int     done;
    int     r;
    int     len;
    bit     ext;
    fault_t fault;
    first = words_sent;
    done = 0;
    while (done < 1050) begin
      // stretches without any idling at the start and in the middle
      no_gaps = done < 150 || (done >= 500 && done < 620);
      r = $urandom_range(99);
      if      (r < 55) fault = F_NONE;
      else if (r < 62) fault = F_START;
      else if (r < 69) fault = F_LCS;
      else if (r < 74) fault = F_ZERO_LEN;
      else if (r < 81) fault = F_DCS;
      else if (r < 87) fault = F_POST;
      else if (r < 94) fault = F_TIMEOUT;
      else             fault = F_NOISE;
      if (fault == F_NOISE) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(9) == 0) send_word(timeout_word());
          else send_word(byte_word(8'($urandom)));
        end
      end else begin
        ext = $urandom_range(9) < 3;
        r = $urandom_range(99);
        if (ext) len = (r < 92) ? $urandom_range(1, 24) : $urandom_range(256, 330);
        else if (r < 78) len = $urandom_range(1, 8);
        else if (r < 94) len = $urandom_range(9, 64);
        else if (r < 98) len = $urandom_range(65, 254);
        else len = 255;
        send_frame(fault, ext, len);
      end
      if ($urandom_range(99) < 85) resync_header();
      done = words_sent - first;
    end
    no_gaps = 1'b0;
  endtask

  // result side: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold <= long_hold - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d data=%02h last=%0b",
                                  out_word.kind, out_word.out_data, out_word.last));
      end else begin
        want = expected_words.pop_front();
        if (out_word.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_word.kind, want.kind));
        if (out_word.out_data !== want.out_data)
          report_mismatch($sformatf("data %02h, want %02h",
                                    out_word.out_data, want.out_data));
        if (out_word.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_word.last, want.last));
      end
    end
  end

  initial begin
    ph = nfd_pkg::PH_HEADER;
    hdr_cnt = 3'd0;
    hdr[0] = 8'h00;
    hdr[1] = 8'h00;
    hdr[2] = 8'h00;
    frame_len = 16'd0;
    byte_cnt = 16'd0;
    dsum = 8'h00;
    start_bad = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_frames();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("nfc_information_frame_deframer_tb: done, clean");
    else
      $display("nfc_information_frame_deframer_tb: done, errors");
    $finish;
  end

  initial begin
    #10000000;
    $display("nfc_information_frame_deframer_tb: done, errors");
    $finish;
  end

endmodule
